FILE: hdl/dag_pkg.sv
// Shared constants, codes and pipeline payload types for the distance gain unit.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package dag_pkg;

  // Field and format widths.
  localparam int DISTANCE_BITS      = 24;
  localparam int GAIN_FRACTION_BITS = 16;
  localparam int MODEL_BITS         = 2;
  localparam int ROLL_BITS          = 16;
  localparam int ROLL_FRAC          = 12;
  localparam int LOG_FRAC           = 16;
  localparam int MANT_BITS          = 31;

  // Derived widths.
  localparam int GAIN_BITS   = GAIN_FRACTION_BITS + 1;
  localparam int MSB_BITS    = $clog2(DISTANCE_BITS);
  localparam int LOG_BITS    = MSB_BITS + LOG_FRAC;
  localparam int PROD_BITS   = ROLL_BITS + DISTANCE_BITS;
  localparam int DIV_BITS    = DISTANCE_BITS + ROLL_FRAC + 5;
  localparam int EXP_BITS    = LOG_BITS + ROLL_BITS;
  localparam int E_BITS      = EXP_BITS - ROLL_FRAC;
  localparam int SEARCH_BITS = GAIN_FRACTION_BITS - 1;
  localparam int TINT_BITS   = $clog2(GAIN_FRACTION_BITS + 1);
  // Divider steps done in each of the LOG_FRAC divider stages.
  localparam int DIV_PER_STAGE = (GAIN_FRACTION_BITS + LOG_FRAC - 1) / LOG_FRAC;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(1) << GAIN_FRACTION_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;
  localparam logic [E_BITS-1:0]    FULL_LOG  = E_BITS'(GAIN_FRACTION_BITS) << LOG_FRAC;

  // Attenuation model codes.
  localparam logic [MODEL_BITS-1:0] MODEL_NONE = 2'd0;
  localparam logic [MODEL_BITS-1:0] MODEL_LIN  = 2'd1;
  localparam logic [MODEL_BITS-1:0] MODEL_INV  = 2'd2;
  localparam logic [MODEL_BITS-1:0] MODEL_EXP  = 2'd3;

  // Which computation still has to produce the gain.
  localparam logic [1:0] PATH_DONE = 2'd0;
  localparam logic [1:0] PATH_LIN  = 2'd1;
  localparam logic [1:0] PATH_INV  = 2'd2;
  localparam logic [1:0] PATH_EXP  = 2'd3;

  // After classification and the rolloff product.
  typedef struct packed {
    logic [1:0]               path;
    logic [GAIN_BITS-1:0]     val;
    logic [PROD_BITS-1:0]     prod;
    logic [DISTANCE_BITS-1:0] span;
    logic [DISTANCE_BITS-1:0] near;
    logic [ROLL_BITS-1:0]     roll;
    logic [MANT_BITS-1:0]     mant_d;
    logic [MANT_BITS-1:0]     mant_n;
    logic [MSB_BITS-1:0]      msb_d;
    logic [MSB_BITS-1:0]      msb_n;
  } dag_cls_t;

  // Divider operands and log mantissas.
  typedef struct packed {
    logic [1:0]           path;
    logic [GAIN_BITS-1:0] val;
    logic [DIV_BITS-1:0]  num;
    logic [DIV_BITS-1:0]  den;
    logic [ROLL_BITS-1:0] roll;
    logic [MANT_BITS-1:0] mant_d;
    logic [MANT_BITS-1:0] mant_n;
    logic [MSB_BITS-1:0]  msb_d;
    logic [MSB_BITS-1:0]  msb_n;
  } dag_div_t;

  // Sideband that rides along the divider and log stages.
  typedef struct packed {
    logic [1:0]           path;
    logic [GAIN_BITS-1:0] val;
    logic [ROLL_BITS-1:0] roll;
    logic [MSB_BITS-1:0]  msb_d;
    logic [MSB_BITS-1:0]  msb_n;
  } dag_rside_t;

  // Gain resolved or log ratio for the exponential model.
  typedef struct packed {
    logic                 done;
    logic [GAIN_BITS-1:0] val;
    logic [LOG_BITS-1:0]  lg;
    logic [ROLL_BITS-1:0] roll;
  } dag_ratio_t;

  // State of the inverse log search.
  typedef struct packed {
    logic                   done;
    logic [GAIN_BITS-1:0]   val;
    logic [LOG_FRAC-1:0]    tfrac;
    logic [TINT_BITS-1:0]   k;
    logic [SEARCH_BITS-1:0] idx;
  } dag_srch_t;

endpackage

FILE: hdl/distance_attenuation_gain_unit.sv
// Top level of the distance attenuation gain unit: pipeline control and output register.
// Depends on dag_pkg, dag_front, dag_ratio and dag_search.
`timescale 1ns / 1ps

// Takes one voice request per cycle while the pipeline advances (model, distance,
// near and far distance in Q16.8, rolloff in Q4.12) and returns its gain in Q1.16,
// in request order. The pipeline is 24 + 17 * (GAIN_FRACTION_BITS - 1) register
// stages deep, counting the output register, for every model.
// That depth is set by the exponential model: two log2 pipes of 16 squaring
// stages each, then 15 search rounds of one 16-stage log2 pipe plus a compare
// stage. The whole pipeline advances together; it holds only while a result
// waits in the output register and the last stage is also occupied, so empty
// slots keep closing up and requests are still taken while a result waits.

module distance_attenuation_gain_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dag_pkg::MODEL_BITS-1:0]        in_model,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     in_distance,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     in_near_distance,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     in_far_distance,
  input  logic [dag_pkg::ROLL_BITS-1:0]         in_rolloff_factor,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dag_pkg::GAIN_BITS-1:0]         out_gain
);

  logic                             adv;
  logic                             out_free;
  logic                             front_vld, ratio_vld, srch_vld;
  dag_pkg::dag_div_t                front_div;
  dag_pkg::dag_ratio_t              ratio;
  logic [dag_pkg::GAIN_BITS-1:0]    srch_gain;
  logic                             out_valid_r;
  logic [dag_pkg::GAIN_BITS-1:0]    gain_r;

  // The pipeline moves when the output slot can take the last stage or
  // when the last stage holds nothing.
  assign out_free = !out_valid_r || out_ready;
  assign adv      = out_free || !srch_vld;
  assign in_ready = adv;

  dag_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (adv),
    .in_valid       (in_valid),
    .model          (in_model),
    .distance       (in_distance),
    .near_distance  (in_near_distance),
    .far_distance   (in_far_distance),
    .rolloff_factor (in_rolloff_factor),
    .vld_o          (front_vld),
    .div_o          (front_div)
  );

  dag_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_i   (front_vld),
    .div_i   (front_div),
    .vld_o   (ratio_vld),
    .ratio_o (ratio)
  );

  dag_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_i   (ratio_vld),
    .ratio_i (ratio),
    .vld_o   (srch_vld),
    .gain_o  (srch_gain)
  );

  // Output register holding the result request until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= srch_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) gain_r <= srch_gain;
  end

  assign out_valid = out_valid_r;
  assign out_gain  = gain_r;

endmodule

FILE: hdl/dag_log_pipe.sv
// Pipelined fractional log2 by repeated squaring: one squaring per stage.
// Depends on dag_pkg; the caller carries its own sideband alongside.
`timescale 1ns / 1ps

module dag_log_pipe (
  input  logic                                clk,
  input  logic                                en,
  input  logic [dag_pkg::MANT_BITS-1:0]       mant_i,
  output logic [dag_pkg::LOG_FRAC-1:0]        frac_o
);

  localparam int MANT = dag_pkg::MANT_BITS;
  localparam int LF   = dag_pkg::LOG_FRAC;

  logic [MANT-1:0] m_r   [LF];
  logic [LF-1:0]   b_r   [LF];
  logic [MANT-1:0] m_nxt [LF];
  logic [LF-1:0]   b_nxt [LF];
  logic [MANT-1:0] m_src [LF];
  logic [LF-1:0]   b_src [LF];

  // Each stage squares the mantissa, keeps it in [1,2) and emits one fraction bit.
  always_comb begin
    logic [2*MANT-1:0] sq;
    logic [MANT:0]     s;
    m_src[0] = mant_i;
    b_src[0] = '0;
    for (int j = 1; j < LF; j++) begin
      m_src[j] = m_r[j-1];
      b_src[j] = b_r[j-1];
    end
    for (int j = 0; j < LF; j++) begin
      sq = m_src[j] * m_src[j];
      s  = sq[2*MANT-1:MANT-1];
      m_nxt[j] = s[MANT] ? s[MANT:1] : s[MANT-1:0];
      b_nxt[j] = {b_src[j][LF-2:0], s[MANT]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LF; j++) begin
        m_r[j] <= m_nxt[j];
        b_r[j] <= b_nxt[j];
      end
    end
  end

  assign frac_o = b_r[LF-1];

endmodule

FILE: hdl/dag_front.sv
// Input register, classification, rolloff product and divider operand setup.
// Depends on dag_pkg.
`timescale 1ns / 1ps

module dag_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [dag_pkg::MODEL_BITS-1:0]        model,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     distance,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     near_distance,
  input  logic [dag_pkg::DISTANCE_BITS-1:0]     far_distance,
  input  logic [dag_pkg::ROLL_BITS-1:0]         rolloff_factor,
  output logic                                  vld_o,
  output dag_pkg::dag_div_t                     div_o
);

  localparam int DB   = dag_pkg::DISTANCE_BITS;
  localparam int MANT = dag_pkg::MANT_BITS;
  localparam int MSBW = dag_pkg::MSB_BITS;
  localparam int PROD = dag_pkg::PROD_BITS;
  localparam int DIVW = dag_pkg::DIV_BITS;

  logic                          s0_vld_r, s1_vld_r, s2_vld_r;
  logic [dag_pkg::MODEL_BITS-1:0] model_r;
  logic [DB-1:0]                 dist_r, near_r, far_r;
  logic [dag_pkg::ROLL_BITS-1:0] roll_r;
  logic [DB-1:0]                 dn;
  dag_pkg::dag_cls_t             cls_nxt, cls_r;
  dag_pkg::dag_div_t             div_nxt, div_r;
  logic [DIVW-1:0]               numl, denl, numi, deni;

  function automatic logic [MSBW-1:0] msb_of(input logic [DB-1:0] x);
    logic [MSBW-1:0] m;
    m = '0;
    for (int i = 0; i < DB; i++) begin
      if (x[i]) m = MSBW'(i);
    end
    return m;
  endfunction

  // Top MANT bits of x once its leading one is moved to the top.
  function automatic logic [MANT-1:0] mant_of(input logic [DB-1:0] x,
                                              input logic [MSBW-1:0] m);
    logic [DB-1:0]      norm;
    logic [DB+MANT-1:0] ext;
    norm = x << (MSBW'(DB - 1) - m);
    ext  = {norm, {MANT{1'b0}}};
    return ext[DB+MANT-1 -: MANT];
  endfunction

  // Stage 1: special cases, range differences, product and normalization.
  assign dn = dist_r - near_r;

  always_comb begin
    cls_nxt.span   = far_r - near_r;
    cls_nxt.near   = near_r;
    cls_nxt.roll   = roll_r;
    cls_nxt.prod   = PROD'(dn) * PROD'(roll_r);
    cls_nxt.msb_d  = msb_of(dist_r);
    cls_nxt.msb_n  = msb_of(near_r);
    cls_nxt.mant_d = mant_of(dist_r, cls_nxt.msb_d);
    cls_nxt.mant_n = mant_of(near_r, cls_nxt.msb_n);
    cls_nxt.path   = dag_pkg::PATH_DONE;
    cls_nxt.val    = dag_pkg::GAIN_ONE;
    if (model_r == dag_pkg::MODEL_NONE || far_r <= near_r || dist_r <= near_r) begin
      cls_nxt.val = dag_pkg::GAIN_ONE;
    end else if (dist_r >= far_r) begin
      cls_nxt.val = dag_pkg::GAIN_ZERO;
    end else begin
      case (model_r)
        dag_pkg::MODEL_LIN: cls_nxt.path = dag_pkg::PATH_LIN;
        dag_pkg::MODEL_INV: cls_nxt.path = dag_pkg::PATH_INV;
        dag_pkg::MODEL_EXP: begin
          if (roll_r == '0) begin
            cls_nxt.val = dag_pkg::GAIN_ONE;
          end else if (near_r == '0) begin
            cls_nxt.val = dag_pkg::GAIN_ZERO;
          end else begin
            cls_nxt.path = dag_pkg::PATH_EXP;
          end
        end
        default: cls_nxt.val = dag_pkg::GAIN_ONE;
      endcase
    end
  end

  // Stage 2: divider operands; a quotient of one or more is settled here.
  assign numl = DIVW'(cls_r.prod);
  assign denl = DIVW'(cls_r.span) << dag_pkg::ROLL_FRAC;
  assign numi = DIVW'(cls_r.near) << dag_pkg::ROLL_FRAC;
  assign deni = numi + DIVW'(cls_r.prod);

  always_comb begin
    div_nxt.path   = cls_r.path;
    div_nxt.val    = cls_r.val;
    div_nxt.roll   = cls_r.roll;
    div_nxt.mant_d = cls_r.mant_d;
    div_nxt.mant_n = cls_r.mant_n;
    div_nxt.msb_d  = cls_r.msb_d;
    div_nxt.msb_n  = cls_r.msb_n;
    div_nxt.num    = numl;
    div_nxt.den    = denl;
    case (cls_r.path)
      dag_pkg::PATH_LIN: begin
        if (numl >= denl) begin
          div_nxt.path = dag_pkg::PATH_DONE;
          div_nxt.val  = dag_pkg::GAIN_ZERO;
        end
      end
      dag_pkg::PATH_INV: begin
        div_nxt.num = numi;
        div_nxt.den = deni;
        if (numi >= deni) begin
          div_nxt.path = dag_pkg::PATH_DONE;
          div_nxt.val  = dag_pkg::GAIN_ONE;
        end
      end
      default: div_nxt.num = numl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      model_r <= model;
      dist_r  <= distance;
      near_r  <= near_distance;
      far_r   <= far_distance;
      roll_r  <= rolloff_factor;
      cls_r   <= cls_nxt;
      div_r   <= div_nxt;
    end
  end

  assign vld_o = s2_vld_r;
  assign div_o = div_r;

endmodule

FILE: hdl/dag_ratio.sv
// Restoring divider for linear/inverse gains beside two log2 pipes for the
// exponential model. Depends on dag_pkg and dag_log_pipe.
`timescale 1ns / 1ps

module dag_ratio (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  dag_pkg::dag_div_t   div_i,
  output logic                vld_o,
  output dag_pkg::dag_ratio_t ratio_o
);

  localparam int NST  = dag_pkg::LOG_FRAC;
  localparam int SPS  = dag_pkg::DIV_PER_STAGE;
  localparam int GFB  = dag_pkg::GAIN_FRACTION_BITS;
  localparam int DIVW = dag_pkg::DIV_BITS;
  localparam int GW   = dag_pkg::GAIN_BITS;

  logic                vld_r   [NST];
  logic [DIVW-1:0]     rem_r   [NST];
  logic [DIVW-1:0]     den_r   [NST];
  logic [GFB-1:0]      q_r     [NST];
  dag_pkg::dag_rside_t side_r  [NST];
  logic [DIVW-1:0]     rem_src [NST];
  logic [DIVW-1:0]     den_src [NST];
  logic [GFB-1:0]      q_src   [NST];
  dag_pkg::dag_rside_t side_src[NST];
  logic [DIVW-1:0]     rem_nxt [NST];
  logic [GFB-1:0]      q_nxt   [NST];
  logic                vld_src [NST];
  logic [dag_pkg::LOG_FRAC-1:0] frac_d, frac_n;
  logic                out_vld_r;
  dag_pkg::dag_ratio_t out_nxt, out_r;
  logic [dag_pkg::LOG_BITS-1:0] lgd, lgn;
  dag_pkg::dag_rside_t side_in;

  assign side_in.path  = div_i.path;
  assign side_in.val   = div_i.val;
  assign side_in.roll  = div_i.roll;
  assign side_in.msb_d = div_i.msb_d;
  assign side_in.msb_n = div_i.msb_n;

  // Log2 of distance and near distance, aligned with the divider stages.
  dag_log_pipe u_log_d (.clk(clk), .en(en), .mant_i(div_i.mant_d), .frac_o(frac_d));
  dag_log_pipe u_log_n (.clk(clk), .en(en), .mant_i(div_i.mant_n), .frac_o(frac_n));

  // Divider stages: each does up to SPS shift-compare-subtract steps.
  always_comb begin
    logic [DIVW:0]   sh;
    logic [DIVW:0]   dif;
    logic            ge;
    logic [DIVW-1:0] rem;
    logic [GFB-1:0]  q;
    rem_src[0]  = div_i.num;
    den_src[0]  = div_i.den;
    q_src[0]    = '0;
    side_src[0] = side_in;
    vld_src[0]  = vld_i;
    for (int j = 1; j < NST; j++) begin
      rem_src[j]  = rem_r[j-1];
      den_src[j]  = den_r[j-1];
      q_src[j]    = q_r[j-1];
      side_src[j] = side_r[j-1];
      vld_src[j]  = vld_r[j-1];
    end
    for (int j = 0; j < NST; j++) begin
      rem = rem_src[j];
      q   = q_src[j];
      for (int s = 0; s < SPS; s++) begin
        if (j * SPS + s < GFB) begin
          sh  = {rem, 1'b0};
          dif = sh - {1'b0, den_src[j]};
          ge  = sh >= {1'b0, den_src[j]};
          rem = ge ? dif[DIVW-1:0] : sh[DIVW-1:0];
          q   = {q[GFB-2:0], ge};
        end
      end
      rem_nxt[j] = rem;
      q_nxt[j]   = q;
    end
  end

  // Final stage: pick the divider gain or hand on the log ratio.
  assign lgd = {side_r[NST-1].msb_d, frac_d};
  assign lgn = {side_r[NST-1].msb_n, frac_n};

  always_comb begin
    out_nxt.lg   = lgd - lgn;
    out_nxt.roll = side_r[NST-1].roll;
    out_nxt.done = 1'b1;
    out_nxt.val  = side_r[NST-1].val;
    case (side_r[NST-1].path)
      dag_pkg::PATH_LIN: out_nxt.val = dag_pkg::GAIN_ONE - GW'(q_r[NST-1]);
      dag_pkg::PATH_INV: out_nxt.val = GW'(q_r[NST-1]);
      dag_pkg::PATH_EXP: out_nxt.done = 1'b0;
      default:           out_nxt.val = side_r[NST-1].val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) vld_r[j] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < NST; j++) vld_r[j] <= vld_src[j];
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NST; j++) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        den_r[j]  <= den_src[j];
        side_r[j] <= side_src[j];
      end
      out_r <= out_nxt;
    end
  end

  assign vld_o   = out_vld_r;
  assign ratio_o = out_r;

endmodule

FILE: hdl/dag_search.sv
// Exponential model: scales the log ratio by rolloff, then finds the gain by a
// bitwise search over log2 evaluations. Depends on dag_pkg and dag_log_pipe.
`timescale 1ns / 1ps

module dag_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  dag_pkg::dag_ratio_t                 ratio_i,
  output logic                                vld_o,
  output logic [dag_pkg::GAIN_BITS-1:0]       gain_o
);

  localparam int SB   = dag_pkg::SEARCH_BITS;
  localparam int LF   = dag_pkg::LOG_FRAC;
  localparam int MANT = dag_pkg::MANT_BITS;
  localparam int EXPW = dag_pkg::EXP_BITS;
  localparam int EW   = dag_pkg::E_BITS;
  localparam int TW   = dag_pkg::TINT_BITS;
  localparam int GW   = dag_pkg::GAIN_BITS;

  logic                         a_vld_r;
  logic                         a_done_r;
  logic [GW-1:0]                a_val_r;
  logic [EW-1:0]                e_r;
  logic [EXPW-1:0]              e_prod;
  logic [EW-1:0]                tgt;
  dag_pkg::dag_srch_t           b_nxt;
  logic                         rnd_vld_r [SB+1];
  dag_pkg::dag_srch_t           rnd_r     [SB+1];
  logic                         fin_vld_r;
  logic [GW-1:0]                fin_r, fin_nxt;
  logic [SB:0]                  g_full, g_shift;

  // Stage A: exponent E = lg * rolloff, rolloff fraction dropped.
  assign e_prod = EXPW'(ratio_i.lg) * EXPW'(ratio_i.roll);

  // Stage B: target log of the gain, with the out-of-range cases settled.
  assign tgt = dag_pkg::FULL_LOG - e_r;

  always_comb begin
    b_nxt.done  = a_done_r;
    b_nxt.val   = a_val_r;
    b_nxt.tfrac = tgt[LF-1:0];
    b_nxt.k     = tgt[LF +: TW];
    b_nxt.idx   = '0;
    if (!a_done_r) begin
      if (e_r > dag_pkg::FULL_LOG) begin
        b_nxt.done = 1'b1;
        b_nxt.val  = dag_pkg::GAIN_ZERO;
      end else if (b_nxt.k >= TW'(dag_pkg::GAIN_FRACTION_BITS)) begin
        b_nxt.done = 1'b1;
        b_nxt.val  = dag_pkg::GAIN_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      rnd_vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r      <= vld_i;
      rnd_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_done_r <= ratio_i.done;
      a_val_r  <= ratio_i.val;
      e_r      <= e_prod[EXPW-1:dag_pkg::ROLL_FRAC];
      rnd_r[0] <= b_nxt;
    end
  end

  // One search round per mantissa bit, most significant first. The log of the
  // candidate mantissa is compared with the target fraction; log2 is monotone,
  // so keeping the bit when it fits gives the largest fitting mantissa.
  for (genvar r = 0; r < SB; r++) begin : g_round
    localparam int POS = SB - 1 - r;
    logic [SB-1:0]      cand, cand_o;
    logic [MANT-1:0]    mant;
    logic [LF-1:0]      frac;
    logic               dvld_r [LF];
    dag_pkg::dag_srch_t dly_r  [LF];
    dag_pkg::dag_srch_t rnd_nxt;

    assign cand = rnd_r[r].idx | (SB'(1) << POS);
    assign mant = {1'b1, cand, {(MANT - 1 - SB){1'b0}}};

    dag_log_pipe u_log (.clk(clk), .en(en), .mant_i(mant), .frac_o(frac));

    assign cand_o = dly_r[LF-1].idx | (SB'(1) << POS);

    always_comb begin
      rnd_nxt = dly_r[LF-1];
      if (frac <= dly_r[LF-1].tfrac) rnd_nxt.idx = cand_o;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int j = 0; j < LF; j++) dvld_r[j] <= 1'b0;
        rnd_vld_r[r+1] <= 1'b0;
      end else if (en) begin
        dvld_r[0] <= rnd_vld_r[r];
        for (int j = 1; j < LF; j++) dvld_r[j] <= dvld_r[j-1];
        rnd_vld_r[r+1] <= dvld_r[LF-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= rnd_r[r];
        for (int j = 1; j < LF; j++) dly_r[j] <= dly_r[j-1];
        rnd_r[r+1] <= rnd_nxt;
      end
    end
  end

  // Final stage: drop the mantissa bits below the gain's own leading one.
  assign g_full  = {1'b1, rnd_r[SB].idx};
  assign g_shift = g_full >> (TW'(SB) - rnd_r[SB].k);
  assign fin_nxt = rnd_r[SB].done ? rnd_r[SB].val : GW'(g_shift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= rnd_vld_r[SB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) fin_r <= fin_nxt;
  end

  assign vld_o  = fin_vld_r;
  assign gain_o = fin_r;

endmodule
